/* rtl/mqtt_received_packet_parser_assert.svh */
// Assertion macros for the received packet parser.
// Each macro expands to one labeled concurrent assertion with a reset guard (disable iff).
`ifndef MQTT_RECEIVED_PACKET_PARSER_ASSERT_SVH
`define MQTT_RECEIVED_PACKET_PARSER_ASSERT_SVH

// Same-cycle implication.
`define MRPP_ASSERT_IMPLY(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("parser assertion failed");

// Next-cycle implication.
`define MRPP_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("parser assertion failed");

`endif

/* rtl/mqtt_rpp_pkg.sv */
// ----------------------------------------------------------------------------
// mqtt_rpp_pkg
// Shared constants and the result record of the received packet parser.
// ----------------------------------------------------------------------------
`default_nettype none

package mqtt_rpp_pkg;

  localparam int MAX_LENGTH_BYTES = 3;
  localparam int LEN_W            = 7 * MAX_LENGTH_BYTES;

  localparam logic [3:0] TYPE_CONNACK = 4'd2;
  localparam logic [3:0] TYPE_PUBLISH = 4'd3;

  localparam logic [1:0] KIND_OTHER            = 2'd0;
  localparam logic [1:0] KIND_CONNACK_ACCEPTED = 2'd1;
  localparam logic [1:0] KIND_CONNACK_REFUSED  = 2'd2;
  localparam logic [1:0] KIND_PUBLISH          = 2'd3;

  localparam logic [2:0] ROLE_HEADER    = 3'd0;
  localparam logic [2:0] ROLE_LENGTH    = 3'd1;
  localparam logic [2:0] ROLE_TOPIC_LEN = 3'd2;
  localparam logic [2:0] ROLE_TOPIC     = 3'd3;
  localparam logic [2:0] ROLE_PACKET_ID = 3'd4;
  localparam logic [2:0] ROLE_PAYLOAD   = 3'd5;
  localparam logic [2:0] ROLE_OTHER     = 3'd6;

  typedef struct packed {
    logic [7:0]  byte_value;
    logic [2:0]  byte_role;
    logic [1:0]  packet_kind;
    logic [1:0]  publish_qos;
    logic [15:0] topic_length;
    logic        last_in_packet;
    logic        malformed;
  } result_t;

endpackage

`default_nettype wire

/* rtl/mqtt_received_packet_parser.sv */
// Timing: a byte accepted into the input register moves on into the result register, which drives
// the result ports, once that register is free or its result is taken.
// Throughput: one byte per cycle while res_stall is low; the parse state updates once per byte in a single pass.
// Reset: synchronous; empties both registers and returns the parser to expecting a header.
// ----------------------------------------------------------------------------
// mqtt_received_packet_parser
// Tags each received MQTT byte with its role and packet information.
// ----------------------------------------------------------------------------
`default_nettype none

`include "mqtt_received_packet_parser_assert.svh"

module mqtt_received_packet_parser (
  input  logic        clk,
  input  logic        rst,
  input  logic        rx_valid,
  output logic        rx_stall,
  input  logic [7:0]  rx_byte,
  output logic        res_valid,
  input  logic        res_stall,
  output logic [7:0]  byte_value,
  output logic [2:0]  byte_role,
  output logic [1:0]  packet_kind,
  output logic [1:0]  publish_qos,
  output logic [15:0] topic_length,
  output logic        last_in_packet,
  output logic        malformed
);
  import mqtt_rpp_pkg::*;

  logic       in_full;
  logic [7:0] in_byte;
  logic       advance;
  result_t    par_result;
  result_t    res_reg;

  // move the held byte into the result register when that slot frees up
  assign advance  = in_full && (!res_valid || !res_stall);
  assign rx_stall = in_full && !advance;

  mqtt_rpp_parser u_parser (
    .clk    (clk),
    .rst    (rst),
    .step   (advance),
    .data   (in_byte),
    .result (par_result)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      in_full <= 1'b0;
    end else if (rx_valid && !rx_stall) begin
      in_full <= 1'b1;
    end else if (advance) begin
      in_full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rx_valid && !rx_stall) begin
      in_byte <= rx_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (advance) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      res_reg <= par_result;
    end
  end

  assign byte_value     = res_reg.byte_value;
  assign byte_role      = res_reg.byte_role;
  assign packet_kind    = res_reg.packet_kind;
  assign publish_qos    = res_reg.publish_qos;
  assign topic_length   = res_reg.topic_length;
  assign last_in_packet = res_reg.last_in_packet;
  assign malformed      = res_reg.malformed;

  `MRPP_ASSERT_IMPLY(a_mal_site, clk, rst, res_valid && malformed, last_in_packet || byte_role == ROLE_TOPIC_LEN)
  `MRPP_ASSERT_IMPLY(a_header_not_last, clk, rst, res_valid && byte_role == ROLE_HEADER, !last_in_packet && !malformed)
  `MRPP_ASSERT_IMPLY(a_topic_publish, clk, rst, res_valid && topic_length != 16'd0, packet_kind == KIND_PUBLISH)
  `MRPP_ASSERT_NEXT(a_stall_holds_byte, clk, rst, rx_stall, in_full)

endmodule

`default_nettype wire

/* rtl/mqtt_rpp_parser.sv */
// ----------------------------------------------------------------------------
// mqtt_rpp_parser
// Per-packet parse state and the single-pass next-state logic for one byte.
// ----------------------------------------------------------------------------
`default_nettype none

module mqtt_rpp_parser (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  step,
  input  logic [7:0]            data,
  output mqtt_rpp_pkg::result_t result
);
  import mqtt_rpp_pkg::*;

  typedef enum logic [2:0] {
    PH_HEADER    = ROLE_HEADER,
    PH_LENGTH    = ROLE_LENGTH,
    PH_TOPIC_LEN = ROLE_TOPIC_LEN,
    PH_TOPIC     = ROLE_TOPIC,
    PH_PACKET_ID = ROLE_PACKET_ID,
    PH_PAYLOAD   = ROLE_PAYLOAD,
    PH_OTHER     = ROLE_OTHER
  } phase_t;

  localparam logic [1:0] LAST_LEN_IDX = 2'(MAX_LENGTH_BYTES - 1);

  phase_t           phase, phase_next;
  logic [3:0]       packet_type, packet_type_next;
  logic [1:0]       qos_bits, qos_bits_next;
  logic [LEN_W-1:0] remaining_count, remaining_count_next;
  logic [1:0]       length_byte_index, length_byte_index_next;
  logic [15:0]      topic_len_reg, topic_len_reg_next;
  logic [15:0]      field_count, field_count_next;
  logic             high_seen, high_seen_next;
  logic [LEN_W-1:0] body_index, body_index_next;
  logic             connack_refused, connack_refused_next;

  logic [LEN_W-1:0] len_part;
  logic [LEN_W-1:0] rc_merged;
  logic [LEN_W-1:0] body_inc;
  logic             body_end;
  logic [15:0]      topic_full;
  logic [15:0]      field_inc;
  phase_t           after_topic;
  logic             mal;
  logic             last;
  logic [1:0]       kind;

  assign len_part    = LEN_W'(data[6:0]) << ({3'b000, length_byte_index} * 5'd7);
  assign rc_merged   = remaining_count | len_part;
  assign body_inc    = body_index + LEN_W'(1);
  assign body_end    = body_inc >= remaining_count;
  assign topic_full  = {field_count[7:0], data};
  assign field_inc   = field_count + 16'd1;
  assign after_topic = (qos_bits != 2'd0) ? PH_PACKET_ID : PH_PAYLOAD;

  always_comb begin
    phase_next             = phase;
    packet_type_next       = packet_type;
    qos_bits_next          = qos_bits;
    remaining_count_next   = remaining_count;
    length_byte_index_next = length_byte_index;
    topic_len_reg_next     = topic_len_reg;
    field_count_next       = field_count;
    high_seen_next         = high_seen;
    body_index_next        = body_index;
    connack_refused_next   = connack_refused;
    mal                    = 1'b0;
    last                   = 1'b0;

    case (phase)
      PH_HEADER: begin
        packet_type_next       = data[7:4];
        qos_bits_next          = data[2:1];
        remaining_count_next   = '0;
        length_byte_index_next = 2'd0;
        topic_len_reg_next     = 16'd0;
        field_count_next       = 16'd0;
        high_seen_next         = 1'b0;
        body_index_next        = '0;
        connack_refused_next   = 1'b0;
        phase_next             = PH_LENGTH;
      end
      PH_LENGTH: begin
        remaining_count_next = rc_merged;
        if (data[7]) begin
          if (length_byte_index == LAST_LEN_IDX) begin
            // overlong length field: drop the packet and resync on next byte
            mal        = 1'b1;
            last       = 1'b1;
            phase_next = PH_HEADER;
          end else begin
            length_byte_index_next = length_byte_index + 2'd1;
          end
        end else if (rc_merged == '0) begin
          last       = 1'b1;
          phase_next = PH_HEADER;
        end else begin
          phase_next = (packet_type == TYPE_PUBLISH) ? PH_TOPIC_LEN : PH_OTHER;
        end
      end
      default: begin
        body_index_next = body_inc;
        case (phase)
          PH_TOPIC_LEN: begin
            if (!high_seen) begin
              high_seen_next   = 1'b1;
              field_count_next = {8'h00, data};
              if (body_end) mal = 1'b1;
            end else begin
              topic_len_reg_next = topic_full;
              field_count_next   = 16'd0;
              high_seen_next     = 1'b0;
              if ((32'(topic_full) + 32'd2) > 32'(remaining_count)) mal = 1'b1;
              phase_next = (topic_full != 16'd0) ? PH_TOPIC : after_topic;
            end
          end
          PH_TOPIC: begin
            field_count_next = field_inc;
            if (field_inc >= topic_len_reg) begin
              field_count_next = 16'd0;
              phase_next       = after_topic;
            end
          end
          PH_PACKET_ID: begin
            field_count_next = field_inc;
            if (field_inc >= 16'd2) begin
              field_count_next = 16'd0;
              phase_next       = PH_PAYLOAD;
            end
          end
          PH_OTHER: begin
            // return code is the second body byte of a connack
            if (packet_type == TYPE_CONNACK && body_inc == LEN_W'(2)) begin
              connack_refused_next = (data != 8'h00);
            end
          end
          default: begin
          end
        endcase
        if (body_end) begin
          last       = 1'b1;
          phase_next = PH_HEADER;
        end
      end
    endcase
  end

  always_comb begin
    if (packet_type_next == TYPE_PUBLISH) begin
      kind = KIND_PUBLISH;
    end else if (packet_type_next == TYPE_CONNACK) begin
      kind = connack_refused_next ? KIND_CONNACK_REFUSED : KIND_CONNACK_ACCEPTED;
    end else begin
      kind = KIND_OTHER;
    end
  end

  always_comb begin
    result.byte_value     = data;
    result.byte_role      = phase;
    result.packet_kind    = kind;
    result.publish_qos    = qos_bits_next;
    result.topic_length   = topic_len_reg_next;
    result.last_in_packet = last;
    result.malformed      = mal;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase             <= PH_HEADER;
      packet_type       <= 4'd0;
      qos_bits          <= 2'd0;
      remaining_count   <= '0;
      length_byte_index <= 2'd0;
      topic_len_reg     <= 16'd0;
      field_count       <= 16'd0;
      high_seen         <= 1'b0;
      body_index        <= '0;
      connack_refused   <= 1'b0;
    end else if (step) begin
      phase             <= phase_next;
      packet_type       <= packet_type_next;
      qos_bits          <= qos_bits_next;
      remaining_count   <= remaining_count_next;
      length_byte_index <= length_byte_index_next;
      topic_len_reg     <= topic_len_reg_next;
      field_count       <= field_count_next;
      high_seen         <= high_seen_next;
      body_index        <= body_index_next;
      connack_refused   <= connack_refused_next;
    end
  end

endmodule

`default_nettype wire

/* dv/mqtt_tag_board_pkg.sv */
// ----------------------------------------------------------------------------
// mqtt_tag_board_pkg
// Tracks the MQTT parse state of the byte stream fed to the parser, works out
// the tag each byte should get, and checks the tags coming back in order.
// ----------------------------------------------------------------------------
package mqtt_tag_board_pkg;

  import mqtt_rpp_pkg::*;

  class mqtt_tag_board;

    logic [2:0]       phase;
    logic [3:0]       ptype;
    logic [1:0]       qos;
    logic [LEN_W-1:0] remain;
    logic [1:0]       len_idx;
    logic [15:0]      topic_size;
    logic [15:0]      field_cnt;
    logic [LEN_W-1:0] body_idx;
    logic             refused;

    result_t tags_due[$];
    int      errors;

    function new();
      phase      = ROLE_HEADER;
      ptype      = '0;
      qos        = '0;
      remain     = '0;
      len_idx    = '0;
      topic_size = '0;
      field_cnt  = '0;
      body_idx   = '0;
      refused    = 1'b0;
      errors     = 0;
    endfunction

    function logic [2:0] after_topic();
      return (qos != 2'd0) ? ROLE_PACKET_ID : ROLE_PAYLOAD;
    endfunction

    // Advance the parse state by one byte and queue the tag it should get.
    function void predict_tag(logic [7:0] b);
      result_t r;
      logic    done;
      r = '0;
      r.byte_value = b;
      r.byte_role = phase;
      if (phase == ROLE_HEADER) begin
        ptype      = b[7:4];
        qos        = b[2:1];
        remain     = '0;
        len_idx    = '0;
        topic_size = '0;
        field_cnt  = '0;
        body_idx   = '0;
        refused    = 1'b0;
        phase      = ROLE_LENGTH;
      end else if (phase == ROLE_LENGTH) begin
        remain |= LEN_W'(b[6:0]) << (7 * len_idx);
        if (b[7]) begin
          if (int'(len_idx) + 1 >= MAX_LENGTH_BYTES) begin
            r.malformed = 1'b1;
            r.last_in_packet = 1'b1;
            phase = ROLE_HEADER;
          end else begin
            len_idx++;
          end
        end else if (remain == '0) begin
          r.last_in_packet = 1'b1;
          phase = ROLE_HEADER;
        end else begin
          phase = (ptype == TYPE_PUBLISH) ? ROLE_TOPIC_LEN : ROLE_OTHER;
        end
      end else begin
        body_idx++;
        done = (body_idx >= remain);
        case (phase)
          ROLE_TOPIC_LEN: begin
            // Bit 8 marks that the high byte is already held.
            if (!field_cnt[8]) begin
              field_cnt = {8'h01, b};
              if (done) r.malformed = 1'b1;
            end else begin
              topic_size = {field_cnt[7:0], b};
              field_cnt = '0;
              if (32'(topic_size) + 32'd2 > 32'(remain)) r.malformed = 1'b1;
              phase = (topic_size != 16'd0) ? ROLE_TOPIC : after_topic();
            end
          end
          ROLE_TOPIC: begin
            field_cnt++;
            if (field_cnt >= topic_size) begin
              field_cnt = '0;
              phase = after_topic();
            end
          end
          ROLE_PACKET_ID: begin
            field_cnt++;
            if (field_cnt >= 16'd2) begin
              field_cnt = '0;
              phase = ROLE_PAYLOAD;
            end
          end
          ROLE_OTHER: begin
            // Return code is the second body byte.
            if (ptype == TYPE_CONNACK && body_idx == LEN_W'(2)) refused = (b != 8'h00);
          end
          default: ;
        endcase
        if (done) begin
          r.last_in_packet = 1'b1;
          phase = ROLE_HEADER;
        end
      end
      if (ptype == TYPE_PUBLISH) r.packet_kind = KIND_PUBLISH;
      else if (ptype == TYPE_CONNACK)
        r.packet_kind = refused ? KIND_CONNACK_REFUSED : KIND_CONNACK_ACCEPTED;
      else r.packet_kind = KIND_OTHER;
      r.publish_qos = qos;
      r.topic_length = topic_size;
      tags_due.push_back(r);
    endfunction

    task report(string what, logic [31:0] got, logic [31:0] want);
      if (errors < 40) $display("mismatch %s: got 0x%0h, expected 0x%0h", what, got, want);
      errors++;
    endtask

    task check_tag(result_t got);
      result_t want;
      if (tags_due.size() == 0) begin
        report("tag with none pending, byte_value", 32'(got.byte_value), 32'hffff_ffff);
        return;
      end
      want = tags_due.pop_front();
      if (got.byte_value !== want.byte_value)
        report("byte_value", 32'(got.byte_value), 32'(want.byte_value));
      if (got.byte_role !== want.byte_role)
        report("byte_role", 32'(got.byte_role), 32'(want.byte_role));
      if (got.packet_kind !== want.packet_kind)
        report("packet_kind", 32'(got.packet_kind), 32'(want.packet_kind));
      if (got.publish_qos !== want.publish_qos)
        report("publish_qos", 32'(got.publish_qos), 32'(want.publish_qos));
      if (got.topic_length !== want.topic_length)
        report("topic_length", 32'(got.topic_length), 32'(want.topic_length));
      if (got.last_in_packet !== want.last_in_packet)
        report("last_in_packet", 32'(got.last_in_packet), 32'(want.last_in_packet));
      if (got.malformed !== want.malformed)
        report("malformed", 32'(got.malformed), 32'(want.malformed));
    endtask

  endclass

endpackage

/* dv/tb.sv */
// ----------------------------------------------------------------------------
// tb
// Feeds the MQTT packet parser a byte stream of directed packets, then random
// packets (some malformed), overlong length fields and noise, with random gaps and
// back-pressure, and checks every tag against a tracked parse state.
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  import mqtt_rpp_pkg::*;
  import mqtt_tag_board_pkg::*;

  localparam int STALL_LIMIT = 5000;
  localparam int RANDOM_BYTES = 2000;

  localparam logic [7:0] DIRECTED_STREAM [27] = '{
    // publish, QoS 1, topic "ab", packet id, one payload byte
    8'h32, 8'h07, 8'h00, 8'h02, 8'h61, 8'h62, 8'h00, 8'h0A, 8'h55,
    // refused connack
    8'h20, 8'h02, 8'h00, 8'h05,
    // zero remaining length
    8'hC0, 8'h00,
    // overlong length field
    8'h10, 8'hFF, 8'hFF, 8'hFF,
    // publish ending inside the topic length
    8'h30, 8'h01, 8'hFF,
    // topic longer than the packet
    8'h30, 8'h03, 8'hFF, 8'hFF, 8'hAA
  };

  logic        clk       = 1'b0;
  logic        rst       = 1'b1;
  logic        rx_valid  = 1'b0;
  logic        rx_stall;
  logic [7:0]  rx_byte   = 8'h00;
  logic        res_valid;
  logic        res_stall = 1'b0;
  logic [7:0]  byte_value;
  logic [2:0]  byte_role;
  logic [1:0]  packet_kind;
  logic [1:0]  publish_qos;
  logic [15:0] topic_length;
  logic        last_in_packet;
  logic        malformed;

  mqtt_tag_board sb;
  int n_sent      = 0;
  int quiet_from  = 32'h4000_0000;
  int idle_cycles = 0;
  wire quiet = (n_sent >= quiet_from) && (n_sent < quiet_from + 400);

  mqtt_received_packet_parser i_dut (.*);

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  always @(posedge clk) res_stall <= !quiet && ($urandom_range(99) < 12);

  always @(posedge clk) begin
    if (!rst && res_valid && !res_stall)
      sb.check_tag({byte_value, byte_role, packet_kind, publish_qos, topic_length,
                    last_in_packet, malformed});
  end

  always @(posedge clk) begin
    if (rst || (rx_valid && !rx_stall) || (res_valid && !res_stall)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("TB_ERROR");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  task automatic send_byte(input logic [7:0] b);
    if (!quiet) begin
      while ($urandom_range(99) < 12) begin
        rx_valid <= 1'b0;
        @(posedge clk);
      end
    end
    rx_valid <= 1'b1;
    rx_byte <= b;
    do @(posedge clk); while (rx_stall);
    sb.predict_tag(b);
    n_sent++;
  endtask

  // Run out whatever packet is open; length bytes keep the continuation bit so
  // an open length field ends as overlong.
  task automatic finish_packet();
    logic [7:0] b;
    while (sb.phase != ROLE_HEADER) begin
      b = 8'($urandom_range(255));
      if (sb.phase == ROLE_LENGTH) b[7] = 1'b1;
      send_byte(b);
    end
  endtask

  task automatic send_packet();
    logic [3:0] ptype;
    logic [3:0] flags;
    logic [7:0] lb;
    logic [7:0] body[$];
    int rem;
    int tlen;
    int nlen;
    int pick;
    pick = $urandom_range(99);
    flags = 4'($urandom_range(15));
    if (pick < 45) ptype = TYPE_PUBLISH;
    else if (pick < 70) ptype = TYPE_CONNACK;
    else ptype = 4'($urandom_range(15));
    body = {};
    if (ptype == TYPE_PUBLISH) begin
      case ($urandom_range(9))
        0: begin
          // topic longer than the packet
          tlen = $urandom_range(1, 65535);
          rem = $urandom_range(2, (tlen + 1 < 30) ? tlen + 1 : 30);
        end
        1: begin
          tlen = $urandom_range(0, 65535);
          rem = $urandom_range(0, 1);
        end
        default: begin
          tlen = ($urandom_range(19) == 0) ? $urandom_range(100, 300) : $urandom_range(0, 12);
          rem = 2 + tlen + ((flags[2:1] != 2'd0) ? 2 : 0) + $urandom_range(0, 10);
        end
      endcase
      body.push_back(tlen[15:8]);
      body.push_back(tlen[7:0]);
    end else if (ptype == TYPE_CONNACK) begin
      rem = ($urandom_range(3) == 0) ? $urandom_range(0, 5) : 2;
      body.push_back(8'($urandom_range(1)));
      body.push_back(($urandom_range(1) == 0) ? 8'h00 : 8'($urandom_range(1, 255)));
    end else begin
      rem = $urandom_range(0, 20);
    end
    while (body.size() < rem) body.push_back(8'($urandom_range(255)));

    send_byte({ptype, flags});
    nlen = (rem < 128) ? 1 : 2;
    // Pad the length field with zero groups now and then.
    if ($urandom_range(4) == 0) nlen = $urandom_range(nlen, MAX_LENGTH_BYTES);
    for (int k = 0; k < nlen; k++) begin
      lb = 8'((rem >> (7 * k)) & 127);
      if (k < nlen - 1) lb[7] = 1'b1;
      send_byte(lb);
    end
    for (int k = 0; k < rem; k++) send_byte(body[k]);
  endtask

  initial begin
    logic [7:0] b;
    int target;
    int burst;
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    foreach (DIRECTED_STREAM[i]) send_byte(DIRECTED_STREAM[i]);

    // One packet with all three length bytes in use, the last a zero group.
    send_byte(8'($urandom_range(255)));
    send_byte(8'h80 | 8'($urandom_range(127)));
    send_byte(8'h81);
    send_byte(8'h00);
    finish_packet();

    quiet_from = n_sent + 500;
    target = n_sent + RANDOM_BYTES;
    while (n_sent < target) begin
      case ($urandom_range(9))
        0: begin
          send_byte(8'($urandom_range(255)));
          repeat (MAX_LENGTH_BYTES) send_byte(8'h80 | 8'($urandom_range(127)));
        end
        1: begin
          // Noise; hold the remaining length small so the stream resyncs soon.
          burst = $urandom_range(1, 10);
          repeat (burst) begin
            b = 8'($urandom_range(255));
            if (sb.phase == ROLE_LENGTH && !b[7]) begin
              if (sb.len_idx == 2'd1) b[6:1] = 6'd0;
              if (sb.len_idx == 2'd2) b[6:0] = 7'd0;
            end
            send_byte(b);
          end
          finish_packet();
        end
        default: send_packet();
      endcase
    end
    rx_valid <= 1'b0;

    while (sb.tags_due.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

endmodule
